/* design/cpw_pkg.sv */
`default_nettype none
package cpw_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int ADDR_W       = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int COORD_W      = 16;
  localparam int VTX_W        = 2 * COORD_W;
  localparam int LEN_W        = COORD_W + 1;
  localparam int DIST_W       = 24;
  localparam int SUM_W        = LEN_W + ADDR_W;
  localparam int SAT_W        = (SUM_W + 1 > DIST_W) ? SUM_W + 1 : DIST_W;
  localparam int MOD_CNT_W    = $clog2(DIST_W);

  localparam logic [DIST_W-1:0]    PERIM_MAX = {DIST_W{1'b1}};
  localparam logic [MOD_CNT_W-1:0] MOD_LAST  = MOD_CNT_W'(DIST_W - 1);

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_QUERY  = 2'd2
  } cpw_action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PERIM,
    ST_MOD,
    ST_PREP,
    ST_WALK,
    ST_DONE
  } cpw_state_t;

  typedef struct packed {
    logic clear;
    logic append;
    logic perim_upd;
    logic query;
    logic mod_step;
    logic mod_last;
    logic walk_step;
    logic out_load;
  } cpw_cmd_t;

  typedef struct packed {
    logic fault;
    logic need_mod;
    logic hit;
  } cpw_status_t;

  // manhattan step of one edge: along y when x does not change, else along x
  function automatic logic [LEN_W-1:0] edge_len(
    input logic signed [COORD_W-1:0] ax,
    input logic signed [COORD_W-1:0] ay,
    input logic signed [COORD_W-1:0] bx,
    input logic signed [COORD_W-1:0] by
  );
    logic signed [LEN_W-1:0] dx;
    logic signed [LEN_W-1:0] dy;
    logic signed [LEN_W-1:0] d;
    dx = {bx[COORD_W-1], bx} - {ax[COORD_W-1], ax};
    dy = {by[COORD_W-1], by} - {ay[COORD_W-1], ay};
    d  = (dx == '0) ? dy : dx;
    return d[LEN_W-1] ? LEN_W'(-d) : LEN_W'(d);
  endfunction

endpackage
`default_nettype wire

/* design/cpw_ram.sv */
`default_nettype none
module cpw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* design/cpw_ctrl.sv */
`default_nettype none
module cpw_ctrl
  import cpw_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_action,
  output logic             out_valid,
  input  wire logic        out_ready,
  input  wire cpw_status_t status,
  output cpw_cmd_t         cmd
);

  cpw_state_t           state_r, state_nxt;
  logic [MOD_CNT_W-1:0] mod_cnt_r, mod_cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mod_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mod_cnt_r   <= mod_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    mod_cnt_nxt   = mod_cnt_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    in_ready      = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (cpw_action_t'(in_action))
            ACT_CLEAR: begin
              cmd.clear = 1'b1;
            end
            ACT_APPEND: begin
              cmd.append = 1'b1;
              state_nxt  = ST_PERIM;
            end
            ACT_QUERY: begin
              cmd.query   = 1'b1;
              mod_cnt_nxt = '0;
              if (status.fault) begin
                state_nxt = ST_DONE;
              end else if (status.need_mod) begin
                state_nxt = ST_MOD;
              end else begin
                state_nxt = ST_PREP;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_PERIM: begin
        cmd.perim_upd = 1'b1;
        state_nxt     = ST_IDLE;
      end
      ST_MOD: begin
        cmd.mod_step = 1'b1;
        mod_cnt_nxt  = mod_cnt_r + 1'b1;
        if (mod_cnt_r == MOD_LAST) begin
          cmd.mod_last = 1'b1;
          state_nxt    = ST_PREP;
        end
      end
      ST_PREP: begin
        // read of vertex 1, the end of the first edge, is in flight
        state_nxt = ST_WALK;
      end
      ST_WALK: begin
        cmd.walk_step = 1'b1;
        if (status.hit) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

/* design/cpw_dp.sv */
`default_nettype none
module cpw_dp
  import cpw_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire cpw_cmd_t                  cmd,
  output cpw_status_t                    status,
  input  wire logic signed [COORD_W-1:0] in_vertex_x,
  input  wire logic signed [COORD_W-1:0] in_vertex_y,
  input  wire logic [DIST_W-1:0]         in_distance,
  output logic signed [COORD_W-1:0]      out_pos_x,
  output logic signed [COORD_W-1:0]      out_pos_y,
  output logic                           out_fault
);

  logic [CNT_W-1:0]          count_r, count_nxt;
  logic [SUM_W-1:0]          open_sum_r, open_sum_nxt;
  logic [DIST_W-1:0]         perim_r, perim_nxt;
  logic signed [COORD_W-1:0] first_x_r, first_x_nxt, first_y_r, first_y_nxt;
  logic signed [COORD_W-1:0] last_x_r, last_x_nxt, last_y_r, last_y_nxt;
  logic [DIST_W-1:0]         t_r, t_nxt;
  logic [DIST_W-1:0]         rem_r, rem_nxt;
  logic [ADDR_W-1:0]         edge_r, edge_nxt;
  logic signed [COORD_W-1:0] prev_x_r, prev_x_nxt, prev_y_r, prev_y_nxt;
  logic signed [COORD_W-1:0] res_x_r, res_x_nxt, res_y_r, res_y_nxt;
  logic                      res_fault_r, res_fault_nxt;
  logic signed [COORD_W-1:0] out_x_r, out_x_nxt, out_y_r, out_y_nxt;
  logic                      out_fault_r, out_fault_nxt;

  logic                      ram_we;
  logic [ADDR_W-1:0]         ram_raddr;
  logic [VTX_W-1:0]          ram_rdata;

  logic                      not_full;
  logic [SAT_W-1:0]          perim_sum;
  logic [DIST_W:0]           rem_sh;
  logic [DIST_W:0]           rem_sub;
  logic [CNT_W-1:0]          count_m1;
  logic                      last_edge;
  logic signed [COORD_W-1:0] cur_x, cur_y;
  logic signed [LEN_W-1:0]   dx, dy, d;
  logic                      along_y;
  logic [LEN_W-1:0]          len;
  logic [COORD_W-1:0]        step;
  logic signed [COORD_W-1:0] hit_x, hit_y;

  assign not_full = count_r < CNT_W'(MAX_VERTICES);
  assign ram_we   = cmd.append && not_full;
  assign ram_raddr = cmd.walk_step ? edge_r + ADDR_W'(2) : edge_r + ADDR_W'(1);

  cpw_ram #(
    .WIDTH (VTX_W),
    .DEPTH (MAX_VERTICES)
  ) u_vtx_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[ADDR_W-1:0]),
    .wdata ({in_vertex_x, in_vertex_y}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // closing edge back to vertex 0 is added on top of the open chain
  assign perim_sum = SAT_W'(open_sum_r)
                   + SAT_W'(edge_len(last_x_r, last_y_r, first_x_r, first_y_r));

  // restoring remainder, one distance bit per cycle
  assign rem_sh  = {rem_r, t_r[DIST_W-1]};
  assign rem_sub = rem_sh - {1'b0, perim_r};

  // walk of one edge
  assign count_m1  = count_r - 1'b1;
  assign last_edge = edge_r == count_m1[ADDR_W-1:0];
  assign cur_x     = last_edge ? first_x_r : ram_rdata[VTX_W-1:COORD_W];
  assign cur_y     = last_edge ? first_y_r : ram_rdata[COORD_W-1:0];
  assign dx        = {cur_x[COORD_W-1], cur_x} - {prev_x_r[COORD_W-1], prev_x_r};
  assign dy        = {cur_y[COORD_W-1], cur_y} - {prev_y_r[COORD_W-1], prev_y_r};
  assign along_y   = dx == '0;
  assign d         = along_y ? dy : dx;
  assign len       = d[LEN_W-1] ? LEN_W'(-d) : LEN_W'(d);
  assign step      = t_r[COORD_W-1:0];

  always_comb begin
    hit_x = prev_x_r;
    hit_y = prev_y_r;
    if (along_y) begin
      hit_y = d[LEN_W-1] ? prev_y_r - step : prev_y_r + step;
    end else begin
      hit_x = d[LEN_W-1] ? prev_x_r - step : prev_x_r + step;
    end
  end

  assign status.fault    = (count_r == '0) || (perim_r == '0);
  assign status.need_mod = in_distance > perim_r;
  assign status.hit      = t_r <= DIST_W'(len);

  always_comb begin
    count_nxt     = count_r;
    open_sum_nxt  = open_sum_r;
    perim_nxt     = perim_r;
    first_x_nxt   = first_x_r;
    first_y_nxt   = first_y_r;
    last_x_nxt    = last_x_r;
    last_y_nxt    = last_y_r;
    t_nxt         = t_r;
    rem_nxt       = rem_r;
    edge_nxt      = edge_r;
    prev_x_nxt    = prev_x_r;
    prev_y_nxt    = prev_y_r;
    res_x_nxt     = res_x_r;
    res_y_nxt     = res_y_r;
    res_fault_nxt = res_fault_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_fault_nxt = out_fault_r;

    if (cmd.clear) begin
      count_nxt    = '0;
      open_sum_nxt = '0;
      perim_nxt    = '0;
    end

    if (ram_we) begin
      if (count_r == '0) begin
        first_x_nxt  = in_vertex_x;
        first_y_nxt  = in_vertex_y;
        open_sum_nxt = '0;
      end else begin
        open_sum_nxt = open_sum_r
                     + SUM_W'(edge_len(last_x_r, last_y_r, in_vertex_x, in_vertex_y));
      end
      last_x_nxt = in_vertex_x;
      last_y_nxt = in_vertex_y;
      count_nxt  = count_r + 1'b1;
    end

    if (cmd.perim_upd) begin
      perim_nxt = (perim_sum > SAT_W'(PERIM_MAX)) ? PERIM_MAX : perim_sum[DIST_W-1:0];
    end

    if (cmd.query) begin
      t_nxt         = in_distance;
      rem_nxt       = '0;
      edge_nxt      = '0;
      prev_x_nxt    = first_x_r;
      prev_y_nxt    = first_y_r;
      res_x_nxt     = '0;
      res_y_nxt     = '0;
      res_fault_nxt = status.fault;
    end

    if (cmd.mod_step) begin
      rem_nxt = rem_sub[DIST_W] ? rem_sh[DIST_W-1:0] : rem_sub[DIST_W-1:0];
      t_nxt   = cmd.mod_last ? rem_nxt : {t_r[DIST_W-2:0], 1'b0};
    end

    if (cmd.walk_step) begin
      if (status.hit) begin
        res_x_nxt = hit_x;
        res_y_nxt = hit_y;
      end else begin
        t_nxt      = t_r - DIST_W'(len);
        prev_x_nxt = cur_x;
        prev_y_nxt = cur_y;
        edge_nxt   = edge_r + 1'b1;
      end
    end

    if (cmd.out_load) begin
      out_x_nxt     = res_x_r;
      out_y_nxt     = res_y_r;
      out_fault_nxt = res_fault_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      open_sum_r <= '0;
      perim_r    <= '0;
    end else begin
      count_r    <= count_nxt;
      open_sum_r <= open_sum_nxt;
      perim_r    <= perim_nxt;
    end
  end

  always_ff @(posedge clk) begin
    first_x_r   <= first_x_nxt;
    first_y_r   <= first_y_nxt;
    last_x_r    <= last_x_nxt;
    last_y_r    <= last_y_nxt;
    t_r         <= t_nxt;
    rem_r       <= rem_nxt;
    edge_r      <= edge_nxt;
    prev_x_r    <= prev_x_nxt;
    prev_y_r    <= prev_y_nxt;
    res_x_r     <= res_x_nxt;
    res_y_r     <= res_y_nxt;
    res_fault_r <= res_fault_nxt;
    out_x_r     <= out_x_nxt;
    out_y_r     <= out_y_nxt;
    out_fault_r <= out_fault_nxt;
  end

  assign out_pos_x = out_x_r;
  assign out_pos_y = out_y_r;
  assign out_fault = out_fault_r;

endmodule
`default_nettype wire

/* design/closed_path_position_walk_top.sv */
// Position along a closed axis-aligned path.
// Input channel (in_valid/in_ready) carries one request: in_action selects
// clear path, append vertex (in_vertex_x/y) or query (in_distance).
// Only a query returns a result on the output channel (out_valid/out_ready):
// out_pos_x/out_pos_y of the point reached walking from vertex 0, or
// out_fault when the path is empty or its perimeter is zero.
// Clear is done on acceptance; append stores the vertex, then updates the
// perimeter. A query is accepted, reduces the distance by a restoring
// remainder (one bit per cycle) when it exceeds the perimeter, starts the
// read of the end of the first edge, then walks the path edge by edge, since
// each edge needs one read of the vertex ram, then loads the output register
// (a faulting query goes straight to it). Requests are handled one at a
// time; in_ready is high while no request is in progress.
// The result sits in an output register, so a new request can be taken while
// it waits; a query that finishes before the receiver takes the previous
// result waits until the output register is free.
// Reset empties the path (no vertices, perimeter zero) and clears out_valid.
`default_nettype none
module closed_path_position_walk_top
  import cpw_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [1:0]                in_action,
  input  wire logic signed [COORD_W-1:0] in_vertex_x,
  input  wire logic signed [COORD_W-1:0] in_vertex_y,
  input  wire logic [DIST_W-1:0]         in_distance,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic signed [COORD_W-1:0]      out_pos_x,
  output logic signed [COORD_W-1:0]      out_pos_y,
  output logic                           out_fault
);

  cpw_cmd_t    cmd;
  cpw_status_t status;

  cpw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_action (in_action),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  cpw_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .status      (status),
    .in_vertex_x (in_vertex_x),
    .in_vertex_y (in_vertex_y),
    .in_distance (in_distance),
    .out_pos_x   (out_pos_x),
    .out_pos_y   (out_pos_y),
    .out_fault   (out_fault)
  );

endmodule
`default_nettype wire

/* test/tb_top.sv */
`timescale 1ns / 100ps
module tb_top
  import cpw_pkg::*;
();

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef coord_t coord_row_t [MAX_VERTICES];

  typedef struct {
    logic [1:0]        action;
    coord_t            vx;
    coord_t            vy;
    logic [DIST_W-1:0] travel;
  } path_req_t;

  typedef struct {
    coord_t px;
    coord_t py;
    logic   fault;
  } walk_point_t;

  localparam logic [1:0] ACT_NONE = 2'd3;  // unused code, must be ignored
  localparam int TOTAL_REQS  = 1250;
  localparam int PHASE_LEN   = 120;
  localparam int HOLD_AT     = 400;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN       = 120;
  localparam int CYCLE_LIMIT = 1000000;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [1:0]                in_action = ACT_CLEAR;
  logic signed [COORD_W-1:0] in_vertex_x = '0;
  logic signed [COORD_W-1:0] in_vertex_y = '0;
  logic [DIST_W-1:0]         in_distance = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [COORD_W-1:0] out_pos_x;
  logic signed [COORD_W-1:0] out_pos_y;
  logic                      out_fault;

  closed_path_position_walk_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_action  (in_action),
    .in_vertex_x(in_vertex_x),
    .in_vertex_y(in_vertex_y),
    .in_distance(in_distance),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_pos_x  (out_pos_x),
    .out_pos_y  (out_pos_y),
    .out_fault  (out_fault)
  );

  path_req_t   pending_reqs[$];
  walk_point_t expected_points[$];
  int          reqs_taken = 0;
  int          error_count = 0;
  int          cycle_count = 0;
  int          hold_left = 0;
  bit          held_once = 1'b0;

  // path as the block should hold it
  coord_row_t        walk_x;
  coord_row_t        walk_y;
  int                walk_count = 0;
  logic [DIST_W-1:0] walk_perim = '0;

  // path as the stimulus builder sees it, used to aim query distances
  coord_row_t gen_x;
  coord_row_t gen_y;
  int         gen_count = 0;

  // signed step of edge i: along y when x does not change, else along x
  function automatic int edge_step(input coord_row_t xs, input coord_row_t ys,
                                   input int count, input int i,
                                   output bit along_y, output int len);
    int j;
    int dx;
    int dy;
    int d;
    j = (i + 1 < count) ? i + 1 : 0;
    dx = int'(xs[j]) - int'(xs[i]);
    dy = int'(ys[j]) - int'(ys[i]);
    along_y = (dx == 0);
    d = along_y ? dy : dx;
    len = (d < 0) ? -d : d;
    return d;
  endfunction

  function automatic logic [DIST_W-1:0] path_perimeter(input coord_row_t xs,
                                                       input coord_row_t ys,
                                                       input int count);
    longint sum;
    bit     ay;
    int     len;
    sum = 0;
    for (int i = 0; i < count; i++) begin
      void'(edge_step(xs, ys, count, i, ay, len));
      sum += len;
    end
    return (sum > longint'(PERIM_MAX)) ? PERIM_MAX : DIST_W'(sum);
  endfunction

  function automatic walk_point_t locate_point(input logic [DIST_W-1:0] travel);
    walk_point_t p;
    int          t;
    int          d;
    int          len;
    bit          ay;
    p.px = '0;
    p.py = '0;
    p.fault = 1'b0;
    if (walk_count == 0 || walk_perim == '0) begin
      p.fault = 1'b1;
      return p;
    end
    t = int'(travel);
    if (t > int'(walk_perim)) t = t % int'(walk_perim);
    p.px = walk_x[0];
    p.py = walk_y[0];
    for (int i = 0; i < walk_count; i++) begin
      d = edge_step(walk_x, walk_y, walk_count, i, ay, len);
      if (t > len) begin
        t -= len;
      end else begin
        p.px = walk_x[i];
        p.py = walk_y[i];
        if (ay) p.py = COORD_W'(int'(walk_y[i]) + ((d > 0) ? t : -t));
        else    p.px = COORD_W'(int'(walk_x[i]) + ((d > 0) ? t : -t));
        break;
      end
    end
    return p;
  endfunction

  task automatic apply_request(input path_req_t r);
    case (r.action)
      ACT_CLEAR: begin
        walk_count = 0;
        walk_perim = '0;
      end
      ACT_APPEND: begin
        if (walk_count < MAX_VERTICES) begin
          walk_x[walk_count] = r.vx;
          walk_y[walk_count] = r.vy;
          walk_count++;
          walk_perim = path_perimeter(walk_x, walk_y, walk_count);
        end
      end
      ACT_QUERY: expected_points.push_back(locate_point(r.travel));
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    error_count++;
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
  endtask

  // idle percentages per phase: none, sender, receiver, both lightly
  function automatic bit idle_roll(input bit for_sender);
    int phase;
    int pct;
    phase = (reqs_taken / PHASE_LEN) % 4;
    case (phase)
      1: pct = for_sender ? 58 : 0;
      2: pct = for_sender ? 0 : 58;
      3: pct = 9;
      default: pct = 0;
    endcase
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic coord_t rand_coord();
    return COORD_W'($urandom);
  endfunction

  function automatic logic [DIST_W-1:0] rand_dist();
    return DIST_W'($urandom);
  endfunction

  function automatic coord_t near(input coord_t c, input int span);
    int lo;
    int hi;
    lo = int'(c) - span;
    hi = int'(c) + span;
    if (lo < -32768) lo = -32768;
    if (hi > 32767) hi = 32767;
    return COORD_W'(lo + int'($urandom_range(0, hi - lo)));
  endfunction

  task automatic push_req(input logic [1:0] action, input coord_t vx, input coord_t vy,
                          input logic [DIST_W-1:0] travel);
    path_req_t r;
    r.action = action;
    r.vx = vx;
    r.vy = vy;
    r.travel = travel;
    pending_reqs.push_back(r);
    if (action == ACT_CLEAR) begin
      gen_count = 0;
    end else if (action == ACT_APPEND && gen_count < MAX_VERTICES) begin
      gen_x[gen_count] = vx;
      gen_y[gen_count] = vy;
      gen_count++;
    end
  endtask

  function automatic logic [DIST_W-1:0] pick_distance();
    longint perim;
    longint d;
    perim = longint'(path_perimeter(gen_x, gen_y, gen_count));
    case ($urandom_range(0, 7))
      0: d = 0;
      1: d = perim;
      2: d = perim + 1;
      3: d = $urandom_range(0, 32'(perim));
      4: d = longint'(rand_dist());
      5: d = perim * $urandom_range(2, 50) + $urandom_range(0, 3);
      6: d = $urandom_range(0, 64);
      default: d = (perim > 0) ? perim - 1 : 0;
    endcase
    if (d > longint'(PERIM_MAX)) d = longint'(PERIM_MAX);
    return DIST_W'(d);
  endfunction

  // usually a clear, then a path of random shape, then a few queries mostly aimed at its perimeter
  task automatic add_path_run();
    int     r;
    int     n;
    int     mode;
    int     span;
    int     q;
    coord_t cx;
    coord_t cy;
    if ($urandom_range(0, 9) != 0) push_req(ACT_CLEAR, rand_coord(), rand_coord(), rand_dist());
    r = $urandom_range(0, 99);
    n = (r < 88) ? $urandom_range(0, 10) : (r < 96) ? $urandom_range(11, 63)
                                                    : $urandom_range(64, 70);
    mode = $urandom_range(0, 3);
    span = (mode == 0) ? 6 : (mode == 1) ? 3000 : 65535;
    cx = rand_coord();
    cy = rand_coord();
    for (int v = 0; v < n; v++) begin
      if (v != 0) begin
        if (mode == 3) begin
          // edges that move in both axes, y part ignored
          cx = near(cx, 500);
          cy = near(cy, 500);
        end else if ($urandom_range(0, 1) != 0) begin
          cx = near(cx, span);
        end else begin
          cy = near(cy, span);
        end
      end
      push_req(ACT_APPEND, cx, cy, rand_dist());
    end
    q = $urandom_range(1, 6);
    for (int k = 0; k < q; k++) push_req(ACT_QUERY, rand_coord(), rand_coord(), pick_distance());
  endtask

  task automatic build_requests();
    // empty path, unknown action, single vertex
    push_req(ACT_QUERY, 16'sh7fff, -16'sh8000, '0);
    push_req(ACT_QUERY, rand_coord(), rand_coord(), PERIM_MAX);
    push_req(ACT_NONE, rand_coord(), rand_coord(), rand_dist());
    push_req(ACT_APPEND, -16'sh8000, 16'sh7fff, rand_dist());
    push_req(ACT_QUERY, rand_coord(), rand_coord(), 24'd5);
    // full-scale triangle: x edge, y edge, x edge back with y ignored
    push_req(ACT_APPEND, 16'sh7fff, 16'sh7fff, rand_dist());
    push_req(ACT_APPEND, 16'sh7fff, -16'sh8000, rand_dist());
    push_req(ACT_QUERY, rand_coord(), rand_coord(), 24'd0);
    push_req(ACT_QUERY, rand_coord(), rand_coord(), 24'd65535);
    push_req(ACT_QUERY, rand_coord(), rand_coord(), 24'd65536);
    push_req(ACT_QUERY, rand_coord(), rand_coord(), 24'd196605);
    push_req(ACT_QUERY, rand_coord(), rand_coord(), 24'd196606);
    push_req(ACT_QUERY, rand_coord(), rand_coord(), PERIM_MAX);
    // zero perimeter with several vertices
    push_req(ACT_CLEAR, rand_coord(), rand_coord(), rand_dist());
    for (int i = 0; i < 3; i++) push_req(ACT_APPEND, 16'sd7, -16'sd3, rand_dist());
    push_req(ACT_QUERY, rand_coord(), rand_coord(), 24'd1);
    // zero-length first edge
    push_req(ACT_CLEAR, rand_coord(), rand_coord(), rand_dist());
    push_req(ACT_APPEND, 16'sd5, 16'sd5, rand_dist());
    push_req(ACT_APPEND, 16'sd5, 16'sd5, rand_dist());
    push_req(ACT_APPEND, 16'sd5, 16'sd9, rand_dist());
    push_req(ACT_QUERY, rand_coord(), rand_coord(), 24'd0);
    push_req(ACT_QUERY, rand_coord(), rand_coord(), 24'd2);
    push_req(ACT_QUERY, rand_coord(), rand_coord(), 24'd8);
    push_req(ACT_QUERY, rand_coord(), rand_coord(), 24'd9);

    while (pending_reqs.size() < TOTAL_REQS) begin
      if ($urandom_range(0, 99) < 80) add_path_run();
      else push_req(2'($urandom_range(0, 3)), rand_coord(), rand_coord(), rand_dist());
    end
  endtask

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    build_requests();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_reqs.size() != 0 || expected_points.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (error_count == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

  // request driver: front of the queue stays until it is taken
  always @(posedge clk) begin
    path_req_t taken;
    path_req_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        taken.action = in_action;
        taken.vx = in_vertex_x;
        taken.vy = in_vertex_y;
        taken.travel = in_distance;
        apply_request(taken);
        void'(pending_reqs.pop_front());
        reqs_taken <= reqs_taken + 1;
      end
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() != 0 && !idle_roll(1'b1)) begin
          nxt = pending_reqs[0];
          in_valid <= 1'b1;
          in_action <= nxt.action;
          in_vertex_x <= nxt.vx;
          in_vertex_y <= nxt.vy;
          in_distance <= nxt.travel;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    walk_point_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_points.size() == 0) begin
          report_mismatch("unexpected result, pos_x", out_pos_x, 0);
        end else begin
          want = expected_points.pop_front();
          if (out_pos_x !== want.px) report_mismatch("pos_x", out_pos_x, want.px);
          if (out_pos_y !== want.py) report_mismatch("pos_y", out_pos_y, want.py);
          if (out_fault !== want.fault) report_mismatch("fault", out_fault, want.fault);
        end
      end
    end
  end

  // receiver stalls, with one long hold-off so the output register fills
  // and input backs up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (!held_once && reqs_taken >= HOLD_AT) begin
        out_ready <= 1'b0;
        hold_left <= HOLD_CYCLES;
        held_once <= 1'b1;
      end else begin
        out_ready <= !idle_roll(1'b0);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

endmodule
